// File: rtl/core/voxel_ray_traversal_macros.svh
// ---------------------------------------------------------------------------
// voxel_ray_traversal_macros
// Assertion macros for the voxel ray traversal block.
// ---------------------------------------------------------------------------
`ifndef VOXEL_RAY_TRAVERSAL_MACROS_SVH
`define VOXEL_RAY_TRAVERSAL_MACROS_SVH
// Check that a condition implies a property in the same cycle.
`define VRT_ASSERT_IMP(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// Check that a condition implies a property in the next cycle.
`define VRT_ASSERT_NXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

// File: rtl/core/vrt_pkg.sv
// ---------------------------------------------------------------------------
// vrt_pkg
// Shared types and constants for the voxel ray traversal block.
// ---------------------------------------------------------------------------
package vrt_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CELL_BITS_DEF = 16;
    localparam int T_W = 24;
    localparam int DIR_W = 18;
    localparam int ORG_W = 32;
    localparam logic [T_W-1:0] T_INF = '1;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_ANSWER = 1'b1;

    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_HIT   = 2'd1;
    localparam logic [1:0] KIND_MISS  = 2'd2;

    localparam logic [1:0] STEP_NONE  = 2'd0;
    localparam logic [1:0] STEP_PLUS  = 2'd1;
    localparam logic [1:0] STEP_MINUS = 2'd3;

    localparam logic [2:0] FACE_PX = 3'd0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EVAL,
        S_OUT
    } t_be_state;

    // One queued item from front to back.
    typedef struct packed {
        logic              op;
        logic [ORG_W-1:0]  org_x;
        logic [ORG_W-1:0]  org_y;
        logic [ORG_W-1:0]  org_z;
        logic [DIR_W-1:0]  dir_x;
        logic [DIR_W-1:0]  dir_y;
        logic [DIR_W-1:0]  dir_z;
        logic              occ;
    } t_item;
endpackage

// File: rtl/core/voxel_ray_traversal.sv
// ---------------------------------------------------------------------------
// voxel_ray_traversal
// 3D voxel DDA walker with an APB limit register.
// ---------------------------------------------------------------------------
// A start transaction runs six bit-serial divisions on one shared divider;
// an answer transaction goes through select, step and output. A two-entry
// queue takes input while a result waits. Each transaction yields one
// result, except answers with no active ray, which yield none.
module voxel_ray_traversal #(
    parameter int FRAC_BITS = vrt_pkg::FRAC_BITS_DEF,
    parameter int CELL_BITS = vrt_pkg::CELL_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic signed [31:0] i_origin_x,
    input  logic signed [31:0] i_origin_y,
    input  logic signed [31:0] i_origin_z,
    input  logic signed [17:0] i_dir_x,
    input  logic signed [17:0] i_dir_y,
    input  logic signed [17:0] i_dir_z,
    input  logic        i_occupied,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic signed [15:0] o_voxel_x,
    output logic signed [15:0] o_voxel_y,
    output logic signed [15:0] o_voxel_z,
    output logic [2:0]  o_hit_face
);
    import vrt_pkg::*;

    localparam logic [T_W+FRAC_BITS:0] LIM8 = (T_W+FRAC_BITS+1)'(8) << FRAC_BITS;
    localparam logic [T_W-1:0] DEF_LIM = (LIM8 > (T_W+FRAC_BITS+1)'(T_INF)) ? T_INF
                                         : T_W'(LIM8);

    logic [T_W-1:0] r_max;
    t_item          item, q_item;
    logic           q_valid, q_pop;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {8'd0, r_max} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max <= DEF_LIM;
        else if (psel && penable && pwrite && paddr == 2'd0) r_max <= pwdata[T_W-1:0];
    end

    assign item = '{op: i_operation, org_x: i_origin_x, org_y: i_origin_y,
                    org_z: i_origin_z, dir_x: i_dir_x, dir_y: i_dir_y,
                    dir_z: i_dir_z, occ: i_occupied};

    vrt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(item), .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_item(q_item)
    );

    vrt_back #(.FRAC_BITS(FRAC_BITS), .CELL_BITS(CELL_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_max_dist(r_max),
        .i_q_valid(q_valid), .i_q_item(q_item), .o_q_pop(q_pop),
        .o_valid(o_valid), .i_ready(i_ready), .o_kind(o_kind),
        .o_vx(o_voxel_x), .o_vy(o_voxel_y), .o_vz(o_voxel_z), .o_face(o_hit_face)
    );
endmodule

// File: rtl/core/vrt_front.sv
// ---------------------------------------------------------------------------
// vrt_front
// Input side: accepts transactions into a two-entry queue for the back end.
// ---------------------------------------------------------------------------
module vrt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  vrt_pkg::t_item i_item,
    output logic           o_q_valid,
    input  logic           i_q_pop,
    output vrt_pkg::t_item o_q_item
);
    import vrt_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_item;
    end
endmodule

// File: rtl/core/vrt_div.sv
// ---------------------------------------------------------------------------
// vrt_div
// Restoring divider, one quotient bit per cycle, saturating to infinity.
// ---------------------------------------------------------------------------
module vrt_div #(
    parameter int FRAC_BITS = vrt_pkg::FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [FRAC_BITS:0]      i_num,
    input  logic [vrt_pkg::DIR_W-1:0] i_den,
    output logic                    o_done,
    output logic [vrt_pkg::T_W-1:0] o_quo
);
    import vrt_pkg::*;

    localparam int NW = 2 * FRAC_BITS + 1;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]  r_num;
    logic [NW-1:0]  r_quo;
    logic [DIR_W-1:0] r_rem;
    logic [DIR_W-1:0] r_den;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic [DIR_W:0] trial;
    logic [DIR_W:0] sh;

    assign sh    = {r_rem, r_num[NW-1]};
    assign trial = sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {i_num, {FRAC_BITS{1'b0}}};
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            if (!trial[DIR_W]) begin
                r_rem <= trial[DIR_W-1:0];
                r_quo <= {r_quo[NW-2:0], 1'b1};
            end else begin
                r_rem <= sh[DIR_W-1:0];
                r_quo <= {r_quo[NW-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        if ({{T_W{1'b0}}, r_quo} > {{NW{1'b0}}, T_INF}) o_quo = T_INF;
        else o_quo = T_W'(r_quo);
    end
endmodule

// File: rtl/core/vrt_back.sv
// ---------------------------------------------------------------------------
// vrt_back
// Ray state, start setup through a shared divider, and per-answer stepping.
// ---------------------------------------------------------------------------
module vrt_back #(
    parameter int FRAC_BITS = vrt_pkg::FRAC_BITS_DEF,
    parameter int CELL_BITS = vrt_pkg::CELL_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [vrt_pkg::T_W-1:0] i_max_dist,
    input  logic                    i_q_valid,
    input  vrt_pkg::t_item          i_q_item,
    output logic                    o_q_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [1:0]              o_kind,
    output logic [15:0]             o_vx,
    output logic [15:0]             o_vy,
    output logic [15:0]             o_vz,
    output logic [2:0]              o_face
);
    import vrt_pkg::*;
    `include "voxel_ray_traversal_macros.svh"

    t_be_state r_st, n_st;
    t_item     r_it;
    logic [CELL_BITS-1:0] r_cell [3];
    logic [1:0]     r_step [3];
    logic [T_W-1:0] r_nc [3];
    logic [T_W-1:0] r_inc [3];
    logic [2:0]     r_face;
    logic [T_W-1:0] r_trav;
    logic           r_act;
    logic [2:0]     r_dj;    // division job: axis*2 + (0 crossing, 1 increment)
    logic           r_dstart;

    logic           div_done;
    logic [T_W-1:0] div_q;
    logic [FRAC_BITS:0] num;
    logic [DIR_W-1:0]   den;
    logic [1:0]     dax;
    logic [ORG_W-1:0]   org;
    logic [DIR_W-1:0]   dir;
    logic [1:0]     a;
    logic [T_W:0]   sum;
    logic [T_W-1:0] thr;
    logic           take_q, pop_c;

    assign dax = r_dj[2:1];
    always_comb begin
        case (dax)
            2'd0:    begin org = r_it.org_x; dir = r_it.dir_x; end
            2'd1:    begin org = r_it.org_y; dir = r_it.dir_y; end
            default: begin org = r_it.org_z; dir = r_it.dir_z; end
        endcase
        den = dir[DIR_W-1] ? (DIR_W)'(-dir) : dir;
        if (r_dj[0]) num = {1'b1, {FRAC_BITS{1'b0}}};
        else if (dir[DIR_W-1]) num = {1'b0, org[FRAC_BITS-1:0]};
        else num = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, org[FRAC_BITS-1:0]};
    end

    vrt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(num), .i_den(den), .o_done(div_done), .o_quo(div_q)
    );

    always_comb begin
        if (r_nc[0] < r_nc[1] && r_nc[0] < r_nc[2]) a = 2'd0;
        else if (r_nc[1] < r_nc[2]) a = 2'd1;
        else a = 2'd2;
        sum = {1'b0, r_nc[a]} + {1'b0, r_inc[a]};
        thr = sum[T_W] ? T_INF : sum[T_W-1:0];
    end

    assign take_q = (r_st == S_IDLE) && i_q_valid;

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_q_valid) begin
                if (i_q_item.op == OP_START) n_st = S_DIV;
                else if (r_act) n_st = S_EVAL;
            end
            S_DIV:  if (div_done && r_dj == 3'd5) n_st = S_EVAL;
            S_EVAL: n_st = S_OUT;
            S_OUT:  if (i_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_comb begin
        pop_c = take_q;
        o_valid = (r_st == S_OUT);
    end
    assign o_q_pop = pop_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_act    <= 1'b0;
            r_dstart <= 1'b0;
            r_dj     <= '0;
            r_face   <= FACE_PX;
            r_trav   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_cell[i] <= '0;
                r_step[i] <= STEP_NONE;
                r_nc[i]   <= T_INF;
                r_inc[i]  <= T_INF;
            end
        end else begin
            r_st     <= n_st;
            r_dstart <= 1'b0;
            if (take_q) begin
                r_it <= i_q_item;
                if (i_q_item.op == OP_START) begin
                    r_dj     <= '0;
                    r_dstart <= 1'b1;
                end
            end
            if (r_st == S_DIV && div_done) begin
                if (den == '0) begin
                    r_step[dax] <= STEP_NONE;
                    if (r_dj[0]) r_inc[dax] <= T_INF;
                    else r_nc[dax] <= T_INF;
                end else begin
                    r_step[dax] <= dir[DIR_W-1] ? STEP_MINUS : STEP_PLUS;
                    if (r_dj[0]) r_inc[dax] <= div_q;
                    else r_nc[dax] <= div_q;
                end
                if (!r_dj[0]) r_cell[dax] <= CELL_BITS'({{CELL_BITS{org[ORG_W-1]}},
                                                         org[ORG_W-1:FRAC_BITS]});
                if (r_dj != 3'd5) begin
                    r_dj     <= r_dj + 3'd1;
                    r_dstart <= 1'b1;
                end
            end
            if (r_st == S_EVAL) begin
                if (r_it.op == OP_START) begin
                    r_face <= FACE_PX;
                    r_trav <= '0;
                    r_act  <= (i_max_dist != '0);
                    o_kind <= (i_max_dist != '0) ? KIND_QUERY : KIND_MISS;
                    o_face <= '0;
                    o_vx <= (i_max_dist != '0) ? 16'(r_cell[0]) : '0;
                    o_vy <= (i_max_dist != '0) ? 16'(r_cell[1]) : '0;
                    o_vz <= (i_max_dist != '0) ? 16'(r_cell[2]) : '0;
                end else if (r_it.occ) begin
                    r_act  <= 1'b0;
                    o_kind <= KIND_HIT;
                    o_face <= r_face;
                    o_vx <= 16'(r_cell[0]);
                    o_vy <= 16'(r_cell[1]);
                    o_vz <= 16'(r_cell[2]);
                end else begin
                    logic [CELL_BITS-1:0] nc;
                    nc = r_cell[a];
                    if (r_step[a] == STEP_PLUS) nc = nc + 1'b1;
                    else if (r_step[a] == STEP_MINUS) nc = nc - 1'b1;
                    r_cell[a] <= nc;
                    r_nc[a]   <= thr;
                    r_trav    <= r_nc[a];
                    r_face    <= {a, 1'b0} + {2'b0, (r_step[a] != STEP_PLUS)};
                    o_face    <= '0;
                    if (r_nc[a] < i_max_dist) begin
                        o_kind <= KIND_QUERY;
                        o_vx <= (a == 2'd0) ? 16'(nc) : 16'(r_cell[0]);
                        o_vy <= (a == 2'd1) ? 16'(nc) : 16'(r_cell[1]);
                        o_vz <= (a == 2'd2) ? 16'(nc) : 16'(r_cell[2]);
                    end else begin
                        r_act  <= 1'b0;
                        o_kind <= KIND_MISS;
                        o_vx <= '0; o_vy <= '0; o_vz <= '0;
                    end
                end
            end
        end
    end

    `VRT_ASSERT_IMP(a_pop_idle, i_clk, i_rst_n, o_q_pop, r_st == S_IDLE)
    `VRT_ASSERT_IMP(a_kind_ok, i_clk, i_rst_n, o_valid, o_kind != 2'd3)
    `VRT_ASSERT_NXT(a_eval_out, i_clk, i_rst_n, r_st == S_EVAL, r_st == S_OUT)
endmodule

// File: sim/voxel_ray_traversal_tb.sv
// ---------------------------------------------------------------------------
// voxel_ray_traversal_tb
// Self-checking bench for the voxel DDA walker. A directed table covers reset
// state, field extremes, ties, zero and oversized directions and rays that
// run out; random rays with mostly empty answers follow. Every result is
// compared field by field against the table or a cycle-free model of the
// walk, over several limit settings and with idling on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module voxel_ray_traversal_tb;
    import vrt_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_WAIT  = 300;
    localparam int N_ROWS      = 20;

    typedef struct packed {
        logic        op;
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] oz;
        logic [17:0] dx;
        logic [17:0] dy;
        logic [17:0] dz;
        logic        occ;
    } t_ray_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] vx;
        logic [15:0] vy;
        logic [15:0] vz;
        logic [2:0]  face;
    } t_walk_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_operation = 1'b0;
    logic signed [31:0] i_origin_x = '0;
    logic signed [31:0] i_origin_y = '0;
    logic signed [31:0] i_origin_z = '0;
    logic signed [17:0] i_dir_x = '0;
    logic signed [17:0] i_dir_y = '0;
    logic signed [17:0] i_dir_z = '0;
    logic        i_occupied = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_kind;
    logic signed [15:0] o_voxel_x;
    logic signed [15:0] o_voxel_y;
    logic signed [15:0] o_voxel_z;
    logic [2:0]  o_hit_face;

    voxel_ray_traversal DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_ready(o_ready), .i_operation(i_operation),
        .i_origin_x(i_origin_x), .i_origin_y(i_origin_y), .i_origin_z(i_origin_z),
        .i_dir_x(i_dir_x), .i_dir_y(i_dir_y), .i_dir_z(i_dir_z),
        .i_occupied(i_occupied),
        .o_valid(o_valid), .i_ready(i_ready), .o_kind(o_kind),
        .o_voxel_x(o_voxel_x), .o_voxel_y(o_voxel_y), .o_voxel_z(o_voxel_z),
        .o_hit_face(o_hit_face)
    );

    always #5 i_clk = ~i_clk;

    // walker model state
    logic [15:0] vox_pos [3];
    logic [1:0]  step_dir [3];
    logic [23:0] t_next [3];
    logic [23:0] t_inc [3];
    logic [2:0]  last_face;
    logic [23:0] t_done;
    logic        walking;
    logic [23:0] dist_limit;

    t_walk_res expected_walk [$];
    int  errors = 0;
    int  cycles = 0;
    int  send_idle = 0;
    int  recv_stall = 0;

    t_ray_item row_stim [N_ROWS];
    bit        row_typed [N_ROWS];
    bit        row_has [N_ROWS];
    t_walk_res row_res [N_ROWS];

    function automatic logic [23:0] t_sat(logic [63:0] v);
        return (v > 64'hFFFFFF) ? T_INF : v[23:0];
    endfunction

    function automatic void setup_axis(int a, logic [31:0] o, logic [17:0] d);
        logic [63:0] mag;
        logic [63:0] bnd;
        mag = d[17] ? (64'd262144 - {46'd0, d}) : {46'd0, d};
        vox_pos[a] = o[31:16];
        if (mag == 0) begin
            step_dir[a] = STEP_NONE;
            t_next[a] = T_INF;
            t_inc[a] = T_INF;
        end else begin
            bnd = d[17] ? {48'd0, o[15:0]} : (64'd65536 - {48'd0, o[15:0]});
            step_dir[a] = d[17] ? STEP_MINUS : STEP_PLUS;
            t_next[a] = t_sat((bnd << 16) / mag);
            t_inc[a] = t_sat((64'd1 << 32) / mag);
        end
    endfunction

    function automatic t_walk_res query_or_miss();
        t_walk_res r;
        if (t_done < dist_limit) begin
            r = '{KIND_QUERY, vox_pos[0], vox_pos[1], vox_pos[2], FACE_PX};
        end else begin
            walking = 1'b0;
            r = '{KIND_MISS, 16'd0, 16'd0, 16'd0, FACE_PX};
        end
        return r;
    endfunction

    function automatic bit walk_predict(t_ray_item s, output t_walk_res r);
        int a;
        r = '0;
        if (s.op == OP_START) begin
            setup_axis(0, s.ox, s.dx);
            setup_axis(1, s.oy, s.dy);
            setup_axis(2, s.oz, s.dz);
            last_face = FACE_PX;
            t_done = '0;
            walking = 1'b1;
            r = query_or_miss();
            return 1;
        end
        if (!walking) return 0;
        if (s.occ) begin
            walking = 1'b0;
            r = '{KIND_HIT, vox_pos[0], vox_pos[1], vox_pos[2], last_face};
            return 1;
        end
        if (t_next[0] < t_next[1] && t_next[0] < t_next[2]) a = 0;
        else if (t_next[1] < t_next[2]) a = 1;
        else a = 2;
        t_done = t_next[a];
        t_next[a] = t_sat({40'd0, t_next[a]} + {40'd0, t_inc[a]});
        if (step_dir[a] == STEP_PLUS) vox_pos[a] = vox_pos[a] + 16'd1;
        else if (step_dir[a] == STEP_MINUS) vox_pos[a] = vox_pos[a] - 16'd1;
        last_face = 3'(2 * a + ((step_dir[a] == STEP_PLUS) ? 0 : 1));
        r = query_or_miss();
        return 1;
    endfunction

    function automatic t_ray_item mk(logic op, logic [31:0] ox, logic [31:0] oy,
                                     logic [31:0] oz, logic [17:0] dx, logic [17:0] dy,
                                     logic [17:0] dz, logic occ);
        t_ray_item s;
        s = '{op, ox, oy, oz, dx, dy, dz, occ};
        return s;
    endfunction

    task automatic send_item(t_ray_item s, bit typed, bit has, t_walk_res tres);
        t_walk_res r;
        bit produced;
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= s.op;
        i_origin_x <= s.ox;
        i_origin_y <= s.oy;
        i_origin_z <= s.oz;
        i_dir_x <= s.dx;
        i_dir_y <= s.dy;
        i_dir_z <= s.dz;
        i_occupied <= s.occ;
        do @(posedge i_clk); while (!o_ready);
        produced = walk_predict(s, r);
        if (typed) begin
            if (has) expected_walk.push_back(tres);
        end else if (produced) begin
            expected_walk.push_back(r);
        end
    endtask

    task automatic write_limit(logic [23:0] v);
        i_valid <= 1'b0;
        wait (expected_walk.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 2'd0;
        pwdata <= {8'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        dist_limit = v;
    endtask

    function automatic logic [17:0] rand_dir();
        int p;
        p = $urandom_range(99);
        if (p < 8) return 18'd0;
        if (p < 14) return 18'($urandom);
        if (p < 20) return ($urandom_range(1)) ? 18'sd65536 : -18'sd65536;
        return 18'($signed($urandom_range(131072)) - 65536);
    endfunction

    function automatic logic [31:0] rand_origin();
        if ($urandom_range(99) < 15) return $urandom;
        return 32'($signed($urandom_range(1048576)) - 524288);
    endfunction

    task automatic random_phase(int n_items);
        int sent;
        int run;
        t_walk_res none;
        none = '0;
        sent = 0;
        while (sent < n_items) begin
            if (!walking && $urandom_range(99) < 10) begin
                send_item(mk(OP_ANSWER, $urandom, $urandom, $urandom, 18'($urandom),
                             18'($urandom), 18'($urandom), 1'($urandom)), 0, 0, none);
            end else begin
                send_item(mk(OP_START, rand_origin(), rand_origin(), rand_origin(),
                             rand_dir(), rand_dir(), rand_dir(), 1'($urandom)), 0, 0, none);
                sent++;
                run = $urandom_range(40);
                while (walking && run > 0 && sent < n_items) begin
                    send_item(mk(OP_ANSWER, $urandom, $urandom, $urandom, 18'($urandom),
                                 18'($urandom), 18'($urandom),
                                 $urandom_range(99) < 6), 0, 0, none);
                    sent++;
                    run--;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_walk_res e;
        if (o_valid && i_ready) begin
            if (expected_walk.size() == 0) begin
                $display("%0t: unexpected result kind=%0d", $time, o_kind);
                errors++;
            end else begin
                e = expected_walk.pop_front();
                if (o_kind !== e.kind) begin
                    $display("%0t: kind exp %0d got %0d", $time, e.kind, o_kind);
                    errors++;
                end
                if (o_voxel_x !== e.vx) begin
                    $display("%0t: voxel_x exp %0d got %0d", $time, $signed(e.vx), o_voxel_x);
                    errors++;
                end
                if (o_voxel_y !== e.vy) begin
                    $display("%0t: voxel_y exp %0d got %0d", $time, $signed(e.vy), o_voxel_y);
                    errors++;
                end
                if (o_voxel_z !== e.vz) begin
                    $display("%0t: voxel_z exp %0d got %0d", $time, $signed(e.vz), o_voxel_z);
                    errors++;
                end
                if (o_hit_face !== e.face) begin
                    $display("%0t: hit_face exp %0d got %0d", $time, e.face, o_hit_face);
                    errors++;
                end
            end
        end
        i_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_walk_res none;
        none = '0;
        for (int a = 0; a < 3; a++) begin
            vox_pos[a] = '0;
            step_dir[a] = STEP_NONE;
            t_next[a] = T_INF;
            t_inc[a] = T_INF;
        end
        last_face = FACE_PX;
        t_done = '0;
        walking = 1'b0;
        dist_limit = 24'h080000;

        row_typed = '{default: 0};
        row_has = '{default: 0};
        row_res = '{default: '0};
        row_stim[0] = mk(OP_ANSWER, 0, 0, 0, 0, 0, 0, 1);
        row_typed[0] = 1;
        row_stim[1] = mk(OP_START, 0, 0, 0, 18'sd65536, 0, 0, 1);
        row_typed[1] = 1; row_has[1] = 1;
        row_res[1] = '{KIND_QUERY, 16'd0, 16'd0, 16'd0, FACE_PX};
        row_stim[2] = mk(OP_ANSWER, 0, 0, 0, 0, 0, 0, 1);
        row_typed[2] = 1; row_has[2] = 1;
        row_res[2] = '{KIND_HIT, 16'd0, 16'd0, 16'd0, FACE_PX};
        row_stim[3] = mk(OP_ANSWER, 0, 0, 0, 0, 0, 0, 0);
        row_typed[3] = 1;
        row_stim[4] = mk(OP_START, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                         -18'sd65536, 18'sd65536, 18'sd1, 0);
        row_typed[4] = 1; row_has[4] = 1;
        row_res[4] = '{KIND_QUERY, 16'h7FFF, 16'h8000, 16'h8000, FACE_PX};
        row_stim[5] = mk(OP_ANSWER, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                         18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 0);
        row_stim[6] = mk(OP_ANSWER, 0, 0, 0, 0, 0, 0, 0);
        row_stim[7] = mk(OP_ANSWER, 0, 0, 0, 0, 0, 0, 1);
        row_stim[8] = mk(OP_START, 32'h00010000, 32'h00020000, 32'hFFFF0000, 0, 0, 0, 1);
        row_typed[8] = 1; row_has[8] = 1;
        row_res[8] = '{KIND_QUERY, 16'd1, 16'd2, 16'hFFFF, FACE_PX};
        row_stim[9] = mk(OP_ANSWER, 0, 0, 0, 0, 0, 0, 0);
        row_typed[9] = 1; row_has[9] = 1;
        row_res[9] = '{KIND_MISS, 16'd0, 16'd0, 16'd0, FACE_PX};
        row_stim[10] = mk(OP_START, 32'h00008000, 32'h00008000, 32'h00008000,
                          18'sd65536, 18'sd65536, 18'sd65536, 0);
        row_stim[11] = mk(OP_ANSWER, 0, 0, 0, 0, 0, 0, 0);
        row_stim[12] = mk(OP_ANSWER, 0, 0, 0, 0, 0, 0, 0);
        row_stim[13] = mk(OP_ANSWER, 0, 0, 0, 0, 0, 0, 0);
        row_stim[14] = mk(OP_START, 32'h00004000, 32'hFFFFC000, 32'h00010000,
                          18'h20000, -18'sd65536, -18'sd3000, 0);
        row_stim[15] = mk(OP_ANSWER, 0, 0, 0, 0, 0, 0, 0);
        row_stim[16] = mk(OP_START, 32'h0000FFFF, 32'h00000001, 32'h0,
                          18'sd1, -18'sd1, 18'sd40000, 0);
        row_stim[17] = mk(OP_ANSWER, 0, 0, 0, 0, 0, 0, 0);
        row_stim[18] = mk(OP_ANSWER, 0, 0, 0, 0, 0, 0, 0);
        row_stim[19] = mk(OP_ANSWER, 0, 0, 0, 0, 0, 0, 1);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_ROWS; k++)
            send_item(row_stim[k], row_typed[k], row_has[k], row_res[k]);

        random_phase(300);
        write_limit(24'd0);
        send_idle = 46;
        random_phase(60);
        write_limit(T_INF);
        send_idle = 0;
        recv_stall = 46;
        random_phase(350);
        write_limit(24'($urandom));
        send_idle = 25;
        recv_stall = 25;
        random_phase(300);
        write_limit(24'h030000);
        send_idle = 46;
        recv_stall = 0;
        random_phase(200);
        write_limit(24'h000001);
        send_idle = 0;
        random_phase(80);
        write_limit(24'h080000);
        send_idle = 25;
        recv_stall = 25;
        random_phase(150);

        i_valid <= 1'b0;
        wait (expected_walk.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
